[hw/rtl/assert_macros.svh]
// Assertion helper macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

[hw/rtl/mpts_pkg.sv]
// ----------------------------------------------------------------------------
// mpts_pkg
// Types, codes and constants of the multilevel priority thread scheduler.
// ----------------------------------------------------------------------------
package mpts_pkg;
	localparam int MAX_THREADS_DEF = 16;
	localparam int LEVELS_DEF = 3;

	localparam logic [2:0] OP_CREATE = 3'd0;
	localparam logic [2:0] OP_WAIT = 3'd1;
	localparam logic [2:0] OP_SET = 3'd2;
	localparam logic [2:0] OP_TICK = 3'd3;
	localparam logic [2:0] OP_DISPATCH = 3'd4;
	localparam logic [2:0] OP_REPORT = 3'd5;

	localparam logic [1:0] ST_UNUSED = 2'd0;
	localparam logic [1:0] ST_READY = 2'd1;
	localparam logic [1:0] ST_RUNNING = 2'd2;
	localparam logic [1:0] ST_WAITING = 2'd3;

	localparam logic [1:0] REG_QHIGH = 2'd0;
	localparam logic [1:0] REG_QMID = 2'd1;
	localparam logic [1:0] REG_QLOW = 2'd2;
	localparam logic [1:0] REG_STEP = 2'd3;

	localparam logic [15:0] QHIGH_RST = 16'd100;
	localparam logic [15:0] QMID_RST = 16'd200;
	localparam logic [15:0] QLOW_RST = 16'd300;
	localparam logic [7:0] STEP_RST = 8'd10;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] thread_id;
		logic [1:0] priority_req;
		logic [15:0] ev_num;
	} in_item_t;

	typedef struct packed {
		logic [15:0] create_number;
		logic [3:0] running_thread;
		logic running_valid;
		logic [3:0] woken_thread;
		logic woken_valid;
		logic priority_raised;
		logic signed [15:0] quantum_left;
		logic [31:0] report_ready_time;
		logic [31:0] report_wait_time;
		logic [1:0] report_priority;
		logic [1:0] report_state;
	} out_item_t;
endpackage

[hw/rtl/multilevel_priority_thread_scheduler_top.sv]
// ----------------------------------------------------------------------------
// multilevel_priority_thread_scheduler_top
// Three-level thread scheduler with FIFO ready and wait queues per level.
// ----------------------------------------------------------------------------
// Each item runs through a sequence of states before its result is registered;
// tick walks every slot in turn; set_event examines wait-queue entries and, on a
// match, moves each later entry up one place. A new item is taken only in the
// idle state, and may be taken while the last result waits in its output
// register. Asynchronous active-low reset clears control and slot state; queue
// storage is read only inside a count.
module multilevel_priority_thread_scheduler_top #(
	parameter int MAX_THREADS = mpts_pkg::MAX_THREADS_DEF,
	parameter int LEVELS = mpts_pkg::LEVELS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input mpts_pkg::in_item_t in_item,
	output logic out_valid,
	input logic out_ready,
	output mpts_pkg::out_item_t out_item,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [3:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	localparam int SW = $clog2(MAX_THREADS);
	localparam int CW = $clog2(MAX_THREADS + 1);
	localparam int LW = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int NQ = 2 * LEVELS;
	localparam int QW = $clog2(NQ);
	localparam int MW = $clog2(NQ * MAX_THREADS);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DISP = 4'd1;
	localparam logic [3:0] S_DISP2 = 4'd2;
	localparam logic [3:0] S_TICK = 4'd3;
	localparam logic [3:0] S_SRD = 4'd4;
	localparam logic [3:0] S_SCMP = 4'd5;
	localparam logic [3:0] S_MRD = 4'd6;
	localparam logic [3:0] S_MWR = 4'd7;
	localparam logic [3:0] S_DONE = 4'd8;
	localparam logic [3:0] S_OUT = 4'd9;
	localparam logic [3:0] S_PUSH = 4'd10;

	localparam logic [1:0] REG_QHIGH_L = mpts_pkg::REG_QHIGH;
	localparam logic [1:0] REG_QMID_L = mpts_pkg::REG_QMID;
	localparam logic [1:0] REG_QLOW_L = mpts_pkg::REG_QLOW;

	logic [15:0] qhigh_q, qmid_q, qlow_q;
	logic [7:0] step_q;

	logic [1:0] slot_state_q [MAX_THREADS];
	logic [LW-1:0] level_q [MAX_THREADS];
	logic [15:0] event_q [MAX_THREADS];
	logic [31:0] rtick_q [MAX_THREADS];
	logic [31:0] wtick_q [MAX_THREADS];
	logic [SW-1:0] head_q [NQ];
	logic [CW-1:0] count_q [NQ];
	logic [SW-1:0] run_slot_q;
	logic run_valid_q;
	logic [15:0] run_q;
	logic [15:0] ccount_q;

	// Queue storage: one memory holding all ready and wait queues.
	logic [SW-1:0] qmem [NQ * MAX_THREADS];
	logic [SW-1:0] rd_q;

	logic [3:0] state_q;
	mpts_pkg::in_item_t it_q;
	logic [SW-1:0] idx_q;
	logic [QW-1:0] lvl_q;
	logic [LW-1:0] plvl_q;
	logic [QW-1:0] pq_q;
	logic [SW-1:0] ps_q;
	logic woken_v_q, raised_q;
	logic [SW-1:0] woken_q;
	logic [3:0] after_push_q;
	logic out_valid_q;
	mpts_pkg::out_item_t out_q;

	// Memory port control, driven by the sequencer.
	logic mem_we;
	logic [MW-1:0] mem_wa, mem_ra;
	logic [SW-1:0] mem_wd;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			qmem[mem_wa] <= mem_wd;
		end
		rd_q <= qmem[mem_ra];
	end

	function automatic logic [MW-1:0] addr_of(input logic [QW-1:0] q, input logic [SW-1:0] p);
		addr_of = MW'(q) * MW'(MAX_THREADS) + MW'(p);
	endfunction

	function automatic logic [SW-1:0] wrap(input logic [SW:0] v);
		logic [SW:0] m;
		m = v;
		if (m >= (SW+1)'(MAX_THREADS)) begin
			m = m - (SW+1)'(MAX_THREADS);
		end
		wrap = m[SW-1:0];
	endfunction

	function automatic logic [15:0] quantum_cap(input logic [15:0] v);
		quantum_cap = v[15] ? 16'h7FFF : v;
	endfunction

	logic [15:0] qsel;
	always_comb begin
		if (level_q[ps_q] == LW'(0)) begin
			qsel = qhigh_q;
		end else if (level_q[ps_q] == LW'(1)) begin
			qsel = qmid_q;
		end else begin
			qsel = qlow_q;
		end
	end

	// Lookup of the first non-empty ready level for dispatch.
	logic disp_found;
	logic [QW-1:0] disp_q;
	always_comb begin
		disp_found = 1'b0;
		disp_q = '0;
		for (int l = LEVELS - 1; l >= 0; l--) begin
			if (count_q[l] != '0) begin
				disp_found = 1'b1;
				disp_q = QW'(l);
			end
		end
	end

	// Current search position in the wait queue being scanned.
	logic [QW-1:0] wq;
	assign wq = QW'(LEVELS) + lvl_q;
	logic [SW-1:0] scan_pos, scan_next;
	assign scan_pos = wrap({1'b0, head_q[wq]} + (SW+1)'(idx_q));
	assign scan_next = wrap({1'b0, head_q[wq]} + (SW+1)'(idx_q) + (SW+1)'(1));

	logic [SW-1:0] push_pos;
	assign push_pos = wrap({1'b0, head_q[pq_q]} + (SW+1)'(count_q[pq_q][SW-1:0]));

	logic [SW-1:0] disp_pos;
	assign disp_pos = head_q[disp_q];

	always_comb begin
		mem_we = 1'b0;
		mem_wa = addr_of(pq_q, push_pos);
		mem_wd = ps_q;
		mem_ra = addr_of(disp_q, disp_pos);
		case (state_q)
			S_PUSH: begin
				mem_we = (count_q[pq_q] < CW'(MAX_THREADS));
			end
			S_SRD: begin
				mem_ra = addr_of(wq, scan_pos);
			end
			S_MRD: begin
				mem_ra = addr_of(wq, scan_next);
			end
			S_MWR: begin
				mem_we = 1'b1;
				mem_wa = addr_of(wq, scan_pos);
				mem_wd = rd_q;
			end
			default: begin
			end
		endcase
	end

	// Tick arithmetic on the running quantum.
	logic signed [16:0] qdec;
	assign qdec = $signed({run_q[15], run_q}) - $signed({9'd0, step_q});

	logic tid_ok;
	assign tid_ok = (MAX_THREADS >= 16) ? 1'b1 : (32'(it_q.thread_id) < MAX_THREADS);
	logic [SW-1:0] tid;
	assign tid = SW'(it_q.thread_id);
	logic [LW-1:0] prio;
	assign prio = (32'(it_q.priority_req) >= LEVELS) ? LW'(LEVELS - 1)
		: LW'(it_q.priority_req);

	// The next item may enter while the previous result waits to be taken.
	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_item = out_q;
	assign pready = 1'b1;

	always_comb begin
		case (paddr[3:2])
			REG_QHIGH_L: prdata = {16'd0, qhigh_q};
			REG_QMID_L: prdata = {16'd0, qmid_q};
			REG_QLOW_L: prdata = {16'd0, qlow_q};
			default: prdata = {24'd0, step_q};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qhigh_q <= mpts_pkg::QHIGH_RST;
			qmid_q <= mpts_pkg::QMID_RST;
			qlow_q <= mpts_pkg::QLOW_RST;
			step_q <= mpts_pkg::STEP_RST;
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				mpts_pkg::REG_QHIGH: qhigh_q <= pwdata[15:0];
				mpts_pkg::REG_QMID: qmid_q <= pwdata[15:0];
				mpts_pkg::REG_QLOW: qlow_q <= pwdata[15:0];
				default: step_q <= pwdata[7:0];
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			run_slot_q <= '0;
			run_valid_q <= 1'b0;
			run_q <= '0;
			ccount_q <= '0;
			idx_q <= '0;
			lvl_q <= '0;
			plvl_q <= '0;
			pq_q <= '0;
			ps_q <= '0;
			woken_v_q <= 1'b0;
			woken_q <= '0;
			raised_q <= 1'b0;
			after_push_q <= S_OUT;
			it_q <= '0;
			out_q <= '0;
			for (int i = 0; i < MAX_THREADS; i++) begin
				slot_state_q[i] <= mpts_pkg::ST_UNUSED;
				level_q[i] <= '0;
				event_q[i] <= '0;
				rtick_q[i] <= '0;
				wtick_q[i] <= '0;
			end
			for (int q = 0; q < NQ; q++) begin
				head_q[q] <= '0;
				count_q[q] <= '0;
			end
		end else begin
			// In the output state a taken result is replaced by the new one below.
			if (out_valid_q && out_ready && state_q != S_OUT) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid && in_ready) begin
						it_q <= in_item;
						woken_v_q <= 1'b0;
						woken_q <= '0;
						raised_q <= 1'b0;
						idx_q <= '0;
						lvl_q <= '0;
						case (in_item.op)
							mpts_pkg::OP_CREATE: begin
								ccount_q <= ccount_q + 16'd1;
								state_q <= S_DONE;
							end
							mpts_pkg::OP_WAIT: begin
								if (run_valid_q) begin
									event_q[run_slot_q] <= in_item.ev_num;
									if (level_q[run_slot_q] != '0 && run_q != '0 && !run_q[15]) begin
										level_q[run_slot_q] <= level_q[run_slot_q] - LW'(1);
										raised_q <= 1'b1;
									end
									slot_state_q[run_slot_q] <= mpts_pkg::ST_WAITING;
									pq_q <= QW'(LEVELS) + QW'(level_q[run_slot_q]);
									ps_q <= run_slot_q;
									run_valid_q <= 1'b0;
									after_push_q <= S_DISP;
									state_q <= S_PUSH;
								end else begin
									state_q <= S_DONE;
								end
							end
							mpts_pkg::OP_SET: state_q <= S_SRD;
							mpts_pkg::OP_TICK: begin
								if (run_valid_q) begin
									run_q <= (qdec < -17'sd32768) ? 16'h8000 : qdec[15:0];
								end
								state_q <= S_TICK;
							end
							mpts_pkg::OP_DISPATCH: begin
								if (!run_valid_q) begin
									state_q <= S_DISP;
								end else begin
									state_q <= S_DONE;
								end
							end
							default: begin
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_DONE: begin
					if (it_q.op == mpts_pkg::OP_CREATE && tid_ok
						&& slot_state_q[tid] == mpts_pkg::ST_UNUSED) begin
						slot_state_q[tid] <= mpts_pkg::ST_READY;
						level_q[tid] <= prio;
						event_q[tid] <= '0;
						rtick_q[tid] <= '0;
						wtick_q[tid] <= '0;
						pq_q <= QW'(prio);
						ps_q <= tid;
						after_push_q <= S_OUT;
						state_q <= S_PUSH;
					end else begin
						state_q <= S_OUT;
					end
				end
				S_PUSH: begin
					if (count_q[pq_q] < CW'(MAX_THREADS)) begin
						count_q[pq_q] <= count_q[pq_q] + CW'(1);
					end
					state_q <= after_push_q;
				end
				S_DISP: begin
					if (disp_found) begin
						state_q <= S_DISP2;
					end else begin
						run_valid_q <= 1'b0;
						run_slot_q <= '0;
						run_q <= '0;
						state_q <= S_OUT;
					end
				end
				S_DISP2: begin
					head_q[disp_q] <= wrap({1'b0, head_q[disp_q]} + (SW+1)'(1));
					count_q[disp_q] <= count_q[disp_q] - CW'(1);
					run_slot_q <= rd_q;
					run_valid_q <= 1'b1;
					slot_state_q[rd_q] <= mpts_pkg::ST_RUNNING;
					ps_q <= rd_q;
					state_q <= S_MRD;
					lvl_q <= '0;
					plvl_q <= '1;
				end
				S_TICK: begin
					if (slot_state_q[idx_q] == mpts_pkg::ST_READY && rtick_q[idx_q] != '1) begin
						rtick_q[idx_q] <= rtick_q[idx_q] + 32'd1;
					end
					if (slot_state_q[idx_q] == mpts_pkg::ST_WAITING && wtick_q[idx_q] != '1) begin
						wtick_q[idx_q] <= wtick_q[idx_q] + 32'd1;
					end
					idx_q <= idx_q + SW'(1);
					if (32'(idx_q) == MAX_THREADS - 1) begin
						state_q <= S_OUT;
					end
				end
				S_SRD: begin
					if (CW'(idx_q) >= count_q[wq] || count_q[wq] == '0) begin
						idx_q <= '0;
						if (32'(lvl_q) == LEVELS - 1) begin
							state_q <= S_OUT;
						end else begin
							lvl_q <= lvl_q + QW'(1);
						end
					end else begin
						state_q <= S_SCMP;
					end
				end
				S_SCMP: begin
					if (event_q[rd_q] == it_q.ev_num) begin
						ps_q <= rd_q;
						woken_q <= rd_q;
						woken_v_q <= 1'b1;
						slot_state_q[rd_q] <= mpts_pkg::ST_READY;
						plvl_q <= '0;
						state_q <= S_MRD;
					end else begin
						if (32'(idx_q) == MAX_THREADS - 1) begin
							idx_q <= '0;
							state_q <= (32'(lvl_q) == LEVELS - 1) ? S_OUT : S_SRD;
							if (32'(lvl_q) != LEVELS - 1) begin
								lvl_q <= lvl_q + QW'(1);
							end
						end else begin
							idx_q <= idx_q + SW'(1);
							state_q <= S_SRD;
						end
					end
				end
				S_MRD: begin
					// After dispatch (plvl all ones) this state only loads the quantum.
					if (plvl_q == '1 && !woken_v_q) begin
						run_q <= quantum_cap(qsel);
						state_q <= S_OUT;
					end else if (CW'(idx_q) + CW'(1) >= count_q[wq]) begin
						count_q[wq] <= count_q[wq] - CW'(1);
						pq_q <= QW'(level_q[ps_q]);
						after_push_q <= S_OUT;
						state_q <= S_PUSH;
					end else begin
						state_q <= S_MWR;
					end
				end
				S_MWR: begin
					idx_q <= idx_q + SW'(1);
					state_q <= S_MRD;
				end
				S_OUT: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q <= 1'b1;
						out_q.create_number <= ccount_q;
						out_q.running_thread <= run_valid_q ? 4'(run_slot_q) : 4'd0;
						out_q.running_valid <= run_valid_q;
						out_q.woken_thread <= woken_v_q ? 4'(woken_q) : 4'd0;
						out_q.woken_valid <= woken_v_q;
						out_q.priority_raised <= raised_q;
						out_q.quantum_left <= run_valid_q ? run_q : 16'd0;
						if (it_q.op == mpts_pkg::OP_REPORT && tid_ok) begin
							out_q.report_ready_time <= rtick_q[tid];
							out_q.report_wait_time <= wtick_q[tid];
							out_q.report_priority <= 2'(level_q[tid]);
							out_q.report_state <= slot_state_q[tid];
						end else begin
							out_q.report_ready_time <= '0;
							out_q.report_wait_time <= '0;
							out_q.report_priority <= '0;
							out_q.report_state <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	logic unused_ok;
	assign unused_ok = ^{paddr[1:0], pwdata[31:16]};
endmodule

[hw/rtl/mpts_checker.sv]
// ----------------------------------------------------------------------------
// mpts_checker
// Port-level checks of the scheduler top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module mpts_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input mpts_pkg::out_item_t out_item,
	input logic pready
);
	logic out_wait;
	logic woken_ok;
	logic run_ok;
	assign out_wait = out_valid && !out_ready;
	assign woken_ok = out_item.woken_valid || out_item.woken_thread == 4'd0;
	assign run_ok = out_item.running_valid || out_item.quantum_left == 16'sd0;

	`ASSERT_NEXT(a_hold_result, clk, arst_n, out_wait, out_valid && $stable(out_item), "result not held")
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_valid && in_ready, !in_ready, "ready after item")
	`ASSERT_IMPL(a_woken_zero, clk, arst_n, out_valid, woken_ok, "woken thread without valid")
	`ASSERT_IMPL(a_run_zero, clk, arst_n, out_valid, run_ok, "quantum with nothing running")
	`ASSERT_IMPL(a_pready, clk, arst_n, 1'b1, pready, "pready low")
endmodule

bind multilevel_priority_thread_scheduler_top mpts_checker u_mpts_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
	.out_valid(out_valid), .out_ready(out_ready), .out_item(out_item), .pready(pready)
);
